>>> src/table_driven_dfa_recognizer_top_assert.svh
// Assertion macros for the recognizer's RTL; only tdfa_seq includes them.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define TDFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define TDFA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TDFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define TDFA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/tdfa_pkg.sv
// Shared types, field widths and codes of the DFA recognizer.
// Depends on nothing; the channel interfaces, tdfa_alpha, tdfa_seq, the top and the testbench import it.
package tdfa_pkg;

   // Field widths of the item and result channels.
   localparam int OPC_W      = 3;
   localparam int STATE_W    = 7;
   localparam int SYM_IDX_W  = 4;
   localparam int CHAR_W     = 8;
   localparam int SCNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Default sizes of the stores.
   localparam int DEF_MAX_STATES  = 64;
   localparam int DEF_MAX_SYMBOLS = 16;

   // Item opcodes.
   localparam logic [OPC_W-1:0] OP_ALPHA  = 3'd0;
   localparam logic [OPC_W-1:0] OP_TRANS  = 3'd1;
   localparam logic [OPC_W-1:0] OP_FINAL  = 3'd2;
   localparam logic [OPC_W-1:0] OP_FEED   = 3'd3;
   localparam logic [OPC_W-1:0] OP_FINISH = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 2'd2;

   // Configuration registers as one group.
   typedef struct packed {
      logic [STATE_W-1:0] start_state;
      logic [STATE_W-1:0] state_count;
      logic [SCNT_W-1:0]  symbol_count;
   } cfg_type;

   localparam logic [STATE_W-1:0] STATE_RESET = 7'd1;
   localparam cfg_type CFG_RESET = '{start_state: 7'd1, state_count: 7'd64,
                                     symbol_count: 5'd16};

endpackage

>>> src/tdfa_chan_if.sv
// Valid/ready channel interfaces for the recognizer's items and results.
// Depends on tdfa_pkg for the field widths.
interface tdfa_req_if import tdfa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPC_W-1:0]     opcode;
   logic [STATE_W-1:0]   state_index;
   logic [SYM_IDX_W-1:0] symbol_index;
   logic [CHAR_W-1:0]    char_value;
   logic [STATE_W-1:0]   next_state_value;
   logic                 final_flag;

   modport source (output valid, opcode, state_index, symbol_index, char_value,
                   next_state_value, final_flag, input ready);
   modport sink   (input valid, opcode, state_index, symbol_index, char_value,
                   next_state_value, final_flag, output ready);
endinterface

interface tdfa_rsp_if import tdfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] current_state;
   logic               verdict_valid;
   logic               accepted;
   logic               rejected_early;

   modport source (output valid, current_state, verdict_valid, accepted,
                   rejected_early, input ready);
   modport sink   (input valid, current_state, verdict_valid, accepted,
                   rejected_early, output ready);
endinterface

>>> src/tdfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module tdfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tdfa_alpha.sv
// Alphabet store and parallel first-match lookup of a character.
// Depends on tdfa_pkg for field widths.
module tdfa_alpha import tdfa_pkg::*; #(
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_SYMBOLS)-1:0] wr_slot,
   input  logic [CHAR_W-1:0]              wr_char,
   input  logic [SCNT_W-1:0]              symbol_count,
   input  logic [CHAR_W-1:0]              char_in,
   output logic                           found,
   output logic [$clog2(MAX_SYMBOLS)-1:0] slot
);

   localparam int SY_W   = $clog2(MAX_SYMBOLS);
   localparam int SCMP_W = (SY_W + 1 > SCNT_W ? SY_W + 1 : SCNT_W) + 1;

   logic [CHAR_W-1:0]      alpha_ff [MAX_SYMBOLS];
   logic [MAX_SYMBOLS-1:0] hit;

   // Alphabet entries are written by load items; no reset value.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         alpha_ff[wr_slot] <= wr_char;
      end
   end

   // Compare every slot in use; the lowest matching slot wins.
   always_comb begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         hit[i] = (alpha_ff[i] == char_in) &&
                  (SCMP_W'(i) < SCMP_W'(symbol_count));
      end
      slot = '0;
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            slot = SY_W'(i);
         end
      end
   end

   assign found = |hit;

endmodule

>>> src/tdfa_seq.sv
// Item sequencer: transition and final-mark memories, automaton state,
// and the result register. Depends on tdfa_pkg, tdfa_chan_if, tdfa_alpha,
// tdfa_ram and the assertion macro header.
`include "table_driven_dfa_recognizer_top_assert.svh"

module tdfa_seq import tdfa_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   tdfa_req_if.sink   req,
   tdfa_rsp_if.source rsp
);

   localparam int ST_W     = $clog2(MAX_STATES);
   localparam int SY_W     = $clog2(MAX_SYMBOLS);
   localparam int TR_DEPTH = MAX_STATES << SY_W;
   localparam int CMP_W    = (ST_W + 1 > STATE_W ? ST_W + 1 : STATE_W) + 1;
   localparam int SCMP_W   = (SY_W + 1 > SYM_IDX_W ? SY_W + 1 : SYM_IDX_W) + 1;

   // Work stage registers.
   logic               busy_ff;
   logic [OPC_W-1:0]   op_ff;
   logic               found_ff;
   logic               pres_ok_ff;
   logic               fvalid_ff;

   // Automaton state.
   logic [STATE_W-1:0] present_ff, present_in;
   logic               dead_ff, dead_in;
   logic [MAX_STATES-1:0] fvalid_vec_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [STATE_W-1:0] rsp_state_ff;
   logic               rsp_verdict_ff;
   logic               rsp_acc_ff;
   logic               rsp_rej_ff;

   logic               accept;
   logic               done;
   logic               st_in_store;
   logic               sy_in_store;
   logic               pres_ok;
   logic               next_ok;
   logic [STATE_W-1:0] st_m1;
   logic [STATE_W-1:0] pres_m1;
   logic [ST_W+STATE_W-1:0]   st_wide;
   logic [ST_W+STATE_W-1:0]   pres_wide;
   logic [SY_W+SYM_IDX_W-1:0] sy_wide;
   logic [ST_W-1:0]    st_idx;
   logic [ST_W-1:0]    pres_idx;
   logic [SY_W-1:0]    sy_idx;
   logic               match_found;
   logic [SY_W-1:0]    match_slot;
   logic [STATE_W-1:0] tr_rdata;
   logic               fin_rdata;
   logic               verdict;
   logic               acc;

   // Items are refused during reset and while the work stage is busy.
   assign req.ready = !busy_ff && !reset;
   assign accept    = req.valid && !busy_ff && !reset;
   // The work stage finishes once the result register is free.
   assign done      = busy_ff && (!rsp_valid_ff || rsp.ready);

   // Store addresses derived from the item and the present state.
   assign st_m1     = req.state_index - STATE_W'(1);
   assign pres_m1   = present_ff - STATE_W'(1);
   assign st_wide   = {{ST_W{1'b0}}, st_m1};
   assign pres_wide = {{ST_W{1'b0}}, pres_m1};
   assign sy_wide   = {{SY_W{1'b0}}, req.symbol_index};
   assign st_idx    = st_wide[ST_W-1:0];
   assign pres_idx  = pres_wide[ST_W-1:0];
   assign sy_idx    = sy_wide[SY_W-1:0];

   assign st_in_store = (req.state_index != '0) &&
                        (CMP_W'(req.state_index) <= CMP_W'(MAX_STATES));
   assign sy_in_store = SCMP_W'(req.symbol_index) < SCMP_W'(MAX_SYMBOLS);

   assign pres_ok = (present_ff != '0) &&
                    (CMP_W'(present_ff) <= CMP_W'(cfg.state_count)) &&
                    (CMP_W'(present_ff) <= CMP_W'(MAX_STATES));
   assign next_ok = (tr_rdata != '0) &&
                    (CMP_W'(tr_rdata) <= CMP_W'(cfg.state_count)) &&
                    (CMP_W'(tr_rdata) <= CMP_W'(MAX_STATES));

   // Alphabet lookup of the fed character.
   tdfa_alpha #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_alpha (
      .clock        (clock),
      .wr_en        (accept && req.opcode == OP_ALPHA && sy_in_store),
      .wr_slot      (sy_idx),
      .wr_char      (req.char_value),
      .symbol_count (cfg.symbol_count),
      .char_in      (req.char_value),
      .found        (match_found),
      .slot         (match_slot)
   );

   // Transition table, addressed by present state and alphabet slot.
   tdfa_ram #(
      .WIDTH (STATE_W),
      .DEPTH (TR_DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (accept && req.opcode == OP_TRANS && st_in_store && sy_in_store),
      .wr_addr ({st_idx, sy_idx}),
      .wr_data (req.next_state_value),
      .rd_en   (accept && req.opcode == OP_FEED),
      .rd_addr ({pres_idx, match_slot}),
      .rd_data (tr_rdata)
   );

   // Final marks; an entry never written reads as not final.
   tdfa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_STATES)
   ) u_final_ram (
      .clock   (clock),
      .wr_en   (accept && req.opcode == OP_FINAL && st_in_store),
      .wr_addr (st_idx),
      .wr_data (req.final_flag),
      .rd_en   (accept && req.opcode == OP_FINISH),
      .rd_addr (pres_idx),
      .rd_data (fin_rdata)
   );

   // Work stage capture and final-mark valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         fvalid_vec_ff <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (accept && req.opcode == OP_FINAL && st_in_store) begin
            fvalid_vec_ff[st_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req.opcode;
         found_ff   <= match_found;
         pres_ok_ff <= pres_ok;
         fvalid_ff  <= fvalid_vec_ff[pres_idx];
      end
   end

   // State update at the end of the work stage.
   always_comb begin
      present_in = present_ff;
      dead_in    = dead_ff;
      verdict    = 1'b0;
      acc        = 1'b0;
      case (op_ff)
         OP_FEED: begin
            if (!dead_ff) begin
               if (!found_ff || !pres_ok_ff || !next_ok) begin
                  dead_in = 1'b1;
               end else begin
                  present_in = tr_rdata;
               end
            end
         end
         OP_FINISH: begin
            verdict    = 1'b1;
            acc        = !dead_ff && pres_ok_ff && fvalid_ff && fin_rdata;
            present_in = cfg.start_state;
            dead_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= STATE_RESET;
         dead_ff    <= 1'b0;
      end else if (done) begin
         present_ff <= present_in;
         dead_ff    <= dead_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_state_ff   <= present_in;
         rsp_verdict_ff <= verdict;
         rsp_acc_ff     <= acc;
         rsp_rej_ff     <= (op_ff == OP_FINISH) ? dead_ff : dead_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.current_state  = rsp_state_ff;
   assign rsp.verdict_valid  = rsp_verdict_ff;
   assign rsp.accepted       = rsp_acc_ff;
   assign rsp.rejected_early = rsp_rej_ff;

   // A finished word puts the automaton back at the start, alive.
   `TDFA_ASSERT_NEXT(a_finish_restart, clock, reset, done && op_ff == OP_FINISH,
      present_ff == cfg.start_state && !dead_ff, "finish did not restart the automaton")
   // Load items and unused opcodes leave the automaton alone.
   `TDFA_ASSERT_NEXT(a_load_keeps_state, clock, reset,
      done && op_ff != OP_FEED && op_ff != OP_FINISH,
      $stable(present_ff) && $stable(dead_ff), "load item changed the automaton")
   // An accepted verdict belongs to a finish item of a live word.
   `TDFA_ASSERT_IMPL(a_accept_consistent, clock, reset, rsp_valid_ff && rsp_acc_ff,
      rsp_verdict_ff && !rsp_rej_ff, "accept without verdict or on doomed word")
   // Completion always leaves a result waiting and frees the work stage.
   `TDFA_ASSERT_NEXT(a_done_loads_result, clock, reset, done,
      rsp_valid_ff && !busy_ff, "completed item did not reach the result register")

endmodule

>>> src/table_driven_dfa_recognizer_top.sv
// Programmable DFA word recognizer. Load items fill the alphabet
// (MAX_SYMBOLS slots of flops, compared in parallel), the transition table
// (a MAX_STATES x MAX_SYMBOLS RAM) and the final marks (a RAM with one
// valid flop per state, so unwritten marks read as not final); feed items
// step the automaton and finish items report the verdict and return to
// start_state. Every item yields one result. For each item the character
// is first matched and the transition and final-mark RAMs are read, then
// the state updates and the result register loads; a new item is taken
// only once the work stage is free, and a stalled result register holds
// the work stage. The user must write configuration through csr_wr_en,
// csr_index and csr_wdata only while the block is idle; the block itself
// does not enforce this. Depends on tdfa_pkg, tdfa_chan_if and tdfa_seq.
module table_driven_dfa_recognizer_top import tdfa_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   tdfa_req_if.sink              req,
   tdfa_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   // Configuration register write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_STATE:  cfg_in.start_state  = csr_wdata[STATE_W-1:0];
            CSR_STATE_COUNT:  cfg_in.state_count  = csr_wdata[STATE_W-1:0];
            CSR_SYMBOL_COUNT: cfg_in.symbol_count = csr_wdata[SCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Item sequencer with the stores.
   tdfa_seq #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the table-driven DFA recognizer.
// Uses tdfa_pkg, the tdfa_req_if/tdfa_rsp_if channels and table_driven_dfa_recognizer_top.
module tb;
   import tdfa_pkg::*;

   // Codes the package leaves unnamed: a spare opcode and the spare register index.
   localparam logic [OPC_W-1:0]     OP_SPARE  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [OPC_W-1:0]     opcode;
      logic [STATE_W-1:0]   state_index;
      logic [SYM_IDX_W-1:0] symbol_index;
      logic [CHAR_W-1:0]    char_value;
      logic [STATE_W-1:0]   next_state_value;
      logic                 final_flag;
   } dfa_item_t;

   typedef struct packed {
      logic [STATE_W-1:0] current_state;
      logic               verdict_valid;
      logic               accepted;
      logic               rejected_early;
   } dfa_report_t;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      dfa_item_t             item;
      logic                  typed;
      dfa_report_t           rep;
   } script_row_t;

   localparam dfa_report_t AT_START = '{current_state: 7'd1, verdict_valid: 1'b0,
                                        accepted: 1'b0, rejected_early: 1'b0};
   localparam dfa_report_t FINISH_AT_START = '{current_state: 7'd1, verdict_valid: 1'b1,
                                               accepted: 1'b0, rejected_early: 1'b0};
   localparam dfa_report_t NO_REP = '0;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tdfa_req_if req_ch ();
   tdfa_rsp_if rsp_ch ();

   table_driven_dfa_recognizer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the registers and stores, with a written mark per alphabet and transition entry.
   bit [STATE_W-1:0] sh_start = 7'd1;
   bit [STATE_W-1:0] sh_states = 7'd64;
   bit [SCNT_W-1:0]  sh_symbols = 5'd16;
   bit [CHAR_W-1:0]  sh_alpha [DEF_MAX_SYMBOLS];
   bit               sh_alpha_wr [DEF_MAX_SYMBOLS];
   bit [STATE_W-1:0] sh_trans [DEF_MAX_STATES*DEF_MAX_SYMBOLS];
   bit               sh_trans_wr [DEF_MAX_STATES*DEF_MAX_SYMBOLS];
   bit               sh_final [DEF_MAX_STATES];
   bit [STATE_W-1:0] sh_state = 7'd1;
   bit               sh_dead = 1'b0;

   dfa_report_t awaited_reports [$];
   script_row_t script [$];
   int err_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;

   function automatic int unsigned states_live();
      return (sh_states > DEF_MAX_STATES) ? DEF_MAX_STATES : int'(sh_states);
   endfunction

   function automatic int unsigned symbols_live();
      return (sh_symbols > DEF_MAX_SYMBOLS) ? DEF_MAX_SYMBOLS : int'(sh_symbols);
   endfunction

   function automatic bit state_live(input int unsigned s);
      return (s >= 1) && (s <= states_live());
   endfunction

   function automatic int unsigned trans_slot(input int unsigned st, input int unsigned sy);
      return (st - 1) * DEF_MAX_SYMBOLS + sy;
   endfunction

   // The lowest alphabet slot in use that holds the character wins.
   function automatic bit find_slot(input bit [CHAR_W-1:0] ch, output int unsigned slot);
      slot = 0;
      for (int unsigned i = 0; i < symbols_live(); i++) begin
         if (sh_alpha[i] == ch) begin
            slot = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Applies one accepted item to the shadow state and returns the report it yields.
   function automatic dfa_report_t advance_automaton(input dfa_item_t it);
      dfa_report_t rep;
      int unsigned slot;
      int unsigned nxt;
      rep = '0;
      case (it.opcode)
         OP_ALPHA: begin
            sh_alpha[it.symbol_index] = it.char_value;
            sh_alpha_wr[it.symbol_index] = 1'b1;
         end
         OP_TRANS: begin
            if (it.state_index >= 1 && it.state_index <= DEF_MAX_STATES) begin
               sh_trans[trans_slot(it.state_index, it.symbol_index)] = it.next_state_value;
               sh_trans_wr[trans_slot(it.state_index, it.symbol_index)] = 1'b1;
            end
         end
         OP_FINAL: begin
            if (it.state_index >= 1 && it.state_index <= DEF_MAX_STATES)
               sh_final[it.state_index - 1] = it.final_flag;
         end
         OP_FEED: begin
            if (!sh_dead) begin
               if (!find_slot(it.char_value, slot) || !state_live(sh_state)) begin
                  sh_dead = 1'b1;
               end else begin
                  nxt = sh_trans[trans_slot(sh_state, slot)];
                  if (state_live(nxt)) sh_state = 7'(nxt);
                  else sh_dead = 1'b1;
               end
            end
         end
         OP_FINISH: begin
            rep.verdict_valid = 1'b1;
            if (!sh_dead && state_live(sh_state)) rep.accepted = sh_final[sh_state - 1];
         end
         default: ;
      endcase
      rep.rejected_early = sh_dead;
      if (it.opcode == OP_FINISH) begin
         sh_state = sh_start;
         sh_dead = 1'b0;
      end
      rep.current_state = sh_state;
      return rep;
   endfunction

   function automatic dfa_item_t random_item();
      dfa_item_t it;
      it.opcode = 3'($urandom_range(0, 7));
      it.state_index = 7'($urandom_range(0, 127));
      it.symbol_index = 4'($urandom_range(0, 15));
      it.char_value = 8'($urandom_range(0, 255));
      it.next_state_value = 7'($urandom_range(0, 127));
      it.final_flag = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // A narrow pool half the time, so the alphabet holds duplicate characters.
   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 15));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [STATE_W-1:0] pick_target();
      if (states_live() != 0 && $urandom_range(0, 99) < 90)
         return 7'($urandom_range(1, states_live()));
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic logic [STATE_W-1:0] pick_state();
      if ($urandom_range(0, 99) < 90) return 7'($urandom_range(1, DEF_MAX_STATES));
      return 7'($urandom_range(0, 127));
   endfunction

   // A feed must never compare against an unwritten alphabet slot or step through
   // an unwritten transition; this returns the load that fills the first such gap.
   function automatic bit fill_needed(input dfa_item_t it, output dfa_item_t fill);
      int unsigned slot;
      fill = random_item();
      if (it.opcode != OP_FEED) return 1'b0;
      for (int unsigned i = 0; i < symbols_live(); i++) begin
         if (!sh_alpha_wr[i]) begin
            fill.opcode = OP_ALPHA;
            fill.symbol_index = 4'(i);
            fill.char_value = pick_char();
            return 1'b1;
         end
      end
      if (!sh_dead && find_slot(it.char_value, slot) && state_live(sh_state) &&
          !sh_trans_wr[trans_slot(sh_state, slot)]) begin
         fill.opcode = OP_TRANS;
         fill.state_index = sh_state;
         fill.symbol_index = 4'(slot);
         fill.next_state_value = pick_target();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic dfa_item_t feed_item();
      dfa_item_t it;
      it = random_item();
      it.opcode = OP_FEED;
      if (symbols_live() != 0 && $urandom_range(0, 99) < 88)
         it.char_value = sh_alpha[$urandom_range(0, symbols_live() - 1)];
      else
         it.char_value = pick_char();
      return it;
   endfunction

   function automatic dfa_item_t load_item();
      dfa_item_t it;
      it = random_item();
      case ($urandom_range(0, 2))
         0: begin
            it.opcode = OP_ALPHA;
            it.char_value = pick_char();
         end
         1: begin
            it.opcode = OP_TRANS;
            it.state_index = pick_state();
            it.next_state_value = pick_target();
         end
         default: begin
            it.opcode = OP_FINAL;
            it.state_index = pick_state();
         end
      endcase
      return it;
   endfunction

   function automatic script_row_t op_row(input logic [OPC_W-1:0] op,
                                          input logic [STATE_W-1:0] st,
                                          input logic [SYM_IDX_W-1:0] sy,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [STATE_W-1:0] nx,
                                          input logic fl, input logic typed,
                                          input dfa_report_t rep);
      script_row_t row;
      row = '0;
      row.item = '{opcode: op, state_index: st, symbol_index: sy, char_value: ch,
                   next_state_value: nx, final_flag: fl};
      row.typed = typed;
      row.rep = rep;
      return row;
   endfunction

   function automatic script_row_t csr_row(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] val);
      script_row_t row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // Offers one item, waits for the handshake and records the report it owes.
   task automatic offer(input dfa_item_t it, input logic typed, input dfa_report_t rep);
      dfa_report_t predicted;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= it.opcode;
      req_ch.state_index <= it.state_index;
      req_ch.symbol_index <= it.symbol_index;
      req_ch.char_value <= it.char_value;
      req_ch.next_state_value <= it.next_state_value;
      req_ch.final_flag <= it.final_flag;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_automaton(it);
      awaited_reports.push_back(typed ? rep : predicted);
   endtask

   task automatic send_item(input dfa_item_t it, input logic typed, input dfa_report_t rep);
      dfa_item_t fill;
      while (fill_needed(it, fill)) offer(fill, 1'b0, NO_REP);
      offer(it, typed, rep);
   endtask

   // Drops valid and waits until every report is in and the pipeline has drained.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_START_STATE:  sh_start = val;
         CSR_STATE_COUNT:  sh_states = val;
         CSR_SYMBOL_COUNT: sh_symbols = val[SCNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One setting of the registers, then mostly whole words with some loads and noise.
   task automatic run_phase(input logic [STATE_W-1:0] st, input logic [STATE_W-1:0] ns,
                            input logic [STATE_W-1:0] nsym, input int idle, input int stall,
                            input int count, input int hold);
      int sent;
      int pick;
      dfa_item_t fin;
      settle();
      csr_write(CSR_START_STATE, st);
      csr_write(CSR_STATE_COUNT, ns);
      csr_write(CSR_SYMBOL_COUNT, nsym);
      csr_write(CSR_SPARE, 7'($urandom_range(0, 127)));
      send_idle_pct = idle;
      stall_pct = stall;
      hold_request = hold;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            repeat ($urandom_range(0, 8)) begin
               send_item(feed_item(), 1'b0, NO_REP);
               sent++;
            end
            fin = random_item();
            fin.opcode = OP_FINISH;
            send_item(fin, 1'b0, NO_REP);
         end else if (pick < 85) begin
            send_item(load_item(), 1'b0, NO_REP);
         end else begin
            send_item(random_item(), 1'b0, NO_REP);
         end
         sent++;
      end
   endtask

   // Compares one accepted result with the oldest expectation.
   task automatic check_report();
      dfa_report_t want;
      dfa_report_t got;
      got = '{current_state: rsp_ch.current_state, verdict_valid: rsp_ch.verdict_valid,
              accepted: rsp_ch.accepted, rejected_early: rsp_ch.rejected_early};
      if (awaited_reports.size() == 0) begin
         err_count++;
         if (err_count <= 10)
            $display("unexpected result: state %0d verdict %b accept %b reject %b",
                     got.current_state, got.verdict_valid, got.accepted, got.rejected_early);
         return;
      end
      want = awaited_reports.pop_front();
      if (got.current_state !== want.current_state || got.verdict_valid !== want.verdict_valid ||
          got.accepted !== want.accepted || got.rejected_early !== want.rejected_early) begin
         err_count++;
         if (err_count <= 10)
            $display("mismatch: expected state %0d verdict %b accept %b reject %b, got %0d %b %b %b",
                     want.current_state, want.verdict_valid, want.accepted, want.rejected_early,
                     got.current_state, got.verdict_valid, got.accepted, got.rejected_early);
      end
   endtask

   // Result side: checks each accepted item and decides ready for the next cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_report();
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Stimulus: reset, the directed script, then the random phases.
   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_START_STATE;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_ALPHA;
      req_ch.state_index <= '0;
      req_ch.symbol_index <= '0;
      req_ch.char_value <= '0;
      req_ch.next_state_value <= '0;
      req_ch.final_flag <= 1'b0;

      // Reset values, then a three-state automaton over the characters 0x00 and 0xFF.
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b1, FINISH_AT_START));
      script.push_back(op_row(OP_SPARE, 7'd127, 4'd15, 8'd255, 7'd127, 1'b1, 1'b1, AT_START));
      script.push_back(csr_row(CSR_SYMBOL_COUNT, 7'd2));
      script.push_back(csr_row(CSR_STATE_COUNT, 7'd3));
      script.push_back(op_row(OP_ALPHA, 7'd0, 4'd0, 8'h00, 7'd0, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_ALPHA, 7'd0, 4'd1, 8'hFF, 7'd0, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_ALPHA, 7'd0, 4'd15, 8'hAA, 7'd0, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd1, 4'd0, 8'd0, 7'd2, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd1, 4'd1, 8'd0, 7'd1, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd2, 4'd0, 8'd0, 7'd3, 1'b0, 1'b1, AT_START));
      // State 2 on 0xFF points past the states in use.
      script.push_back(op_row(OP_TRANS, 7'd2, 4'd1, 8'd0, 7'd64, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd3, 4'd0, 8'd0, 7'd3, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd3, 4'd1, 8'd0, 7'd1, 1'b0, 1'b1, AT_START));
      // Loads addressed outside the stores are dropped.
      script.push_back(op_row(OP_TRANS, 7'd0, 4'd15, 8'd0, 7'd127, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_TRANS, 7'd127, 4'd15, 8'd0, 7'd1, 1'b0, 1'b1, AT_START));
      script.push_back(op_row(OP_FINAL, 7'd3, 4'd0, 8'd0, 7'd0, 1'b1, 1'b1, AT_START));
      script.push_back(op_row(OP_FINAL, 7'd127, 4'd0, 8'd0, 7'd0, 1'b1, 1'b1, AT_START));
      script.push_back(op_row(OP_FINAL, 7'd0, 4'd0, 8'd0, 7'd0, 1'b1, 1'b1, AT_START));
      // An accepted word, a word doomed by a bad target, and one by an unknown character.
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'h00, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'h00, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'h00, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'hFF, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'h00, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'h42, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b0, NO_REP));
      // A new start state shows up only at the next finish.
      script.push_back(csr_row(CSR_START_STATE, 7'd3));
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b1,
                              dfa_report_t'{7'd3, 1'b1, 1'b0, 1'b0}));
      script.push_back(op_row(OP_FEED, 7'd0, 4'd0, 8'hFF, 7'd0, 1'b0, 1'b0, NO_REP));
      script.push_back(op_row(OP_FINISH, 7'd0, 4'd0, 8'd0, 7'd0, 1'b0, 1'b0, NO_REP));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            csr_write(script[i].csr_idx, script[i].csr_val);
         end else begin
            send_item(script[i].item, script[i].typed, script[i].rep);
         end
      end

      // The first phase carries the long receiver hold-off while items keep coming.
      run_phase(7'd1, 7'd64, 7'd16, 0, 0, 300, 300);
      run_phase(7'd64, 7'd64, 7'd16, 48, 0, 250, 0);
      run_phase(7'd1, 7'd1, 7'd1, 0, 48, 200, 0);
      run_phase(7'd5, 7'd8, 7'd4, 21, 21, 250, 0);
      run_phase(7'd0, 7'd0, 7'd0, 48, 0, 100, 0);
      run_phase(7'd3, 7'd127, 7'd127, 0, 48, 250, 0);
      run_phase(7'd70, 7'd10, 7'd6, 21, 21, 150, 0);
      run_phase(7'd2, 7'd20, 7'd8, 21, 21, 300, 0);

      req_ch.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/tdfa_pkg.sv
src/tdfa_chan_if.sv
src/tdfa_ram.sv
src/tdfa_alpha.sv
src/tdfa_seq.sv
src/table_driven_dfa_recognizer_top.sv
sim/tb.sv
